[rtl/core/thermal_autorange_false_color_macros.svh]
// Assertion macros shared by the checker of the thermal false-color block.
// No dependencies.
`ifndef THERMAL_AUTORANGE_FALSE_COLOR_MACROS_SVH
`define THERMAL_AUTORANGE_FALSE_COLOR_MACROS_SVH
// implication checked on every clock unless in reset
`define TAFC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tafc check failed");
// implication checked on the next clock
`define TAFC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tafc check failed");
`endif

[rtl/core/tafc_pkg.sv]
// Shared types, constants and the palette table of the thermal false-color block.
// No dependencies.
`timescale 1ns / 1ps
package tafc_pkg;
  localparam int SensorPixels   = 64;
  localparam int PixW           = $clog2(SensorPixels);
  localparam int PaletteEntries = 256;
  localparam int IdxW           = 8;
  localparam int QueueDepth     = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COLOR  = 1'b1;

  localparam logic [1:0] REG_FAST   = 2'd0;
  localparam logic [1:0] REG_SLOW   = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [15:0] FAST_RST   = 16'd6554;
  localparam logic [15:0] SLOW_RST   = 16'd1638;
  localparam logic [15:0] THRESH_RST = 16'd2560;
  localparam logic signed [15:0] LOW_RST  = 16'sd0;
  localparam logic signed [15:0] HIGH_RST = 16'sd7680;
  localparam logic signed [15:0] MIN_RST  = 16'sh7FFF;
  localparam logic signed [15:0] MAX_RST  = 16'sh8000;

  typedef struct packed {
    logic              op;
    logic signed [15:0] temp;
    logic [PixW-1:0]   pix;
    logic              last;
  } item_t;

  typedef struct packed {
    logic signed [15:0] smooth;
    logic [15:0]        color;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic signed [15:0] fmin;
    logic signed [15:0] fmax;
  } result_t;

  function automatic logic [15:0] palette(input logic [IdxW-1:0] i);
    logic [15:0] t [0:255];
    t = '{16'h480F,
      16'h400F,16'h400F,16'h400F,16'h4010,16'h3810,16'h3810,16'h3810,16'h3810,16'h3010,16'h3010,
      16'h3010,16'h2810,16'h2810,16'h2810,16'h2810,16'h2010,16'h2010,16'h2010,16'h1810,16'h1810,
      16'h1811,16'h1811,16'h1011,16'h1011,16'h1011,16'h0811,16'h0811,16'h0811,16'h0011,16'h0011,
      16'h0011,16'h0011,16'h0011,16'h0031,16'h0031,16'h0051,16'h0072,16'h0072,16'h0092,16'h00B2,
      16'h00B2,16'h00D2,16'h00F2,16'h00F2,16'h0112,16'h0132,16'h0152,16'h0152,16'h0172,16'h0192,
      16'h0192,16'h01B2,16'h01D2,16'h01F3,16'h01F3,16'h0213,16'h0233,16'h0253,16'h0253,16'h0273,
      16'h0293,16'h02B3,16'h02D3,16'h02D3,16'h02F3,16'h0313,16'h0333,16'h0333,16'h0353,16'h0373,
      16'h0394,16'h03B4,16'h03D4,16'h03D4,16'h03F4,16'h0414,16'h0434,16'h0454,16'h0474,16'h0474,
      16'h0494,16'h04B4,16'h04D4,16'h04F4,16'h0514,16'h0534,16'h0534,16'h0554,16'h0554,16'h0574,
      16'h0574,16'h0573,16'h0573,16'h0573,16'h0572,16'h0572,16'h0572,16'h0571,16'h0591,16'h0591,
      16'h0590,16'h0590,16'h058F,16'h058F,16'h058F,16'h058E,16'h05AE,16'h05AE,16'h05AD,16'h05AD,
      16'h05AD,16'h05AC,16'h05AC,16'h05AB,16'h05CB,16'h05CB,16'h05CA,16'h05CA,16'h05CA,16'h05C9,
      16'h05C9,16'h05C8,16'h05E8,16'h05E8,16'h05E7,16'h05E7,16'h05E6,16'h05E6,16'h05E6,16'h05E5,
      16'h05E5,16'h0604,16'h0604,16'h0604,16'h0603,16'h0603,16'h0602,16'h0602,16'h0601,16'h0621,
      16'h0621,16'h0620,16'h0620,16'h0620,16'h0620,16'h0E20,16'h0E20,16'h0E40,16'h1640,16'h1640,
      16'h1E40,16'h1E40,16'h2640,16'h2640,16'h2E40,16'h2E60,16'h3660,16'h3660,16'h3E60,16'h3E60,
      16'h3E60,16'h4660,16'h4660,16'h4E60,16'h4E80,16'h5680,16'h5680,16'h5E80,16'h5E80,16'h6680,
      16'h6680,16'h6E80,16'h6EA0,16'h76A0,16'h76A0,16'h7EA0,16'h7EA0,16'h86A0,16'h86A0,16'h8EA0,
      16'h8EC0,16'h96C0,16'h96C0,16'h9EC0,16'h9EC0,16'hA6C0,16'hAEC0,16'hAEC0,16'hB6E0,16'hB6E0,
      16'hBEE0,16'hBEE0,16'hC6E0,16'hC6E0,16'hCEE0,16'hCEE0,16'hD6E0,16'hD700,16'hDF00,16'hDEE0,
      16'hDEC0,16'hDEA0,16'hDE80,16'hDE80,16'hE660,16'hE640,16'hE620,16'hE600,16'hE5E0,16'hE5C0,
      16'hE5A0,16'hE580,16'hE560,16'hE540,16'hE520,16'hE500,16'hE4E0,16'hE4C0,16'hE4A0,16'hE480,
      16'hE460,16'hEC40,16'hEC20,16'hEC00,16'hEBE0,16'hEBC0,16'hEBA0,16'hEB80,16'hEB60,16'hEB40,
      16'hEB20,16'hEB00,16'hEAE0,16'hEAC0,16'hEAA0,16'hEA80,16'hEA60,16'hEA40,16'hF220,16'hF200,
      16'hF1E0,16'hF1C0,16'hF1A0,16'hF180,16'hF160,16'hF140,16'hF100,16'hF0E0,16'hF0C0,16'hF0A0,
      16'hF080,16'hF060,16'hF040,16'hF020,16'hF800};
    return t[i];
  endfunction
endpackage

[rtl/core/tafc_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module tafc_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/tafc_front.sv]
// Front end: a two-entry item queue toward the back end.
// Depends on tafc_pkg.
`timescale 1ns / 1ps
module tafc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tafc_pkg::item_t       in_item,
  output logic                  q_valid,
  input  logic                  q_pop,
  output tafc_pkg::item_t       q_item
);
  import tafc_pkg::*;
  item_t      buf_r [QueueDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + 1'b1;
    rp_nxt  = rp_r + 1'b1;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (q_pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wp_r] <= in_item;
  end
endmodule

[rtl/core/tafc_back.sv]
// Back end: smoothing store, limit tracking and palette lookup with a serial divider.
// Depends on tafc_pkg and tafc_ram.
`timescale 1ns / 1ps
module tafc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  tafc_pkg::item_t      q_item,
  input  logic [15:0]          fast_gain,
  input  logic [15:0]          slow_gain,
  input  logic [15:0]          spread_threshold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tafc_pkg::result_t    out_res
);
  import tafc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SMTH  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_LIM   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_COL   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]   st_r, st_nxt;
  item_t        it_r;
  logic [PixW:0] clr_r;
  logic signed [15:0] low_r, high_r, min_r, max_r, fmin_r, fmax_r, smooth_r;
  logic signed [33:0] pl_r, ph_r;
  logic [24:0]  rem_r;
  logic [16:0]  den_r;
  logic [24:0]  quo_r;
  logic [4:0]   dcnt_r;
  logic [IdxW-1:0] idx_r;
  result_t      res_r;
  logic         ov_r;

  logic             we;
  logic [PixW-1:0]  waddr;
  logic [15:0]      wdata, rdata;

  // smoothing and min/max
  logic signed [16:0] ssum;
  logic signed [15:0] smooth_c, nmin, nmax;
  // limit gains
  logic signed [16:0] spread;
  logic               wide;
  logic [15:0]        kl, kh;
  logic signed [16:0] dl, dh;
  logic signed [17:0] nl, nh;
  // divider step
  logic [25:0]        rtry;
  logic [24:0]        qfin;
  logic signed [16:0] tdiff;

  tafc_ram #(.Width(16), .Depth(SensorPixels)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(it_r.pix), .rdata(rdata)
  );

  function automatic logic signed [17:0] sat_sub(input logic signed [15:0] lim,
                                                 input logic signed [33:0] p);
    logic signed [17:0] d;
    d = 18'(p >>> 16);
    return 18'(lim) - d;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7FFF;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    ssum     = 17'(signed'(rdata)) + 17'(it_r.temp);
    smooth_c = ssum[16:1];
    nmin     = (it_r.temp < min_r) ? it_r.temp : min_r;
    nmax     = (it_r.temp > max_r) ? it_r.temp : max_r;
    spread   = 17'(high_r) - 17'(low_r);
    wide     = spread > signed'({1'b0, spread_threshold});
    kl = (fmin_r < low_r)  ? fast_gain : (wide ? slow_gain : 16'd0);
    kh = (fmax_r > high_r) ? fast_gain : (wide ? slow_gain : 16'd0);
    dl = 17'(low_r) - 17'(fmin_r);
    dh = 17'(high_r) - 17'(fmax_r);
    nl = sat_sub(low_r, pl_r);
    nh = sat_sub(high_r, ph_r);
    rtry  = {rem_r, quo_r[24]} - {9'd0, den_r};
    qfin  = {quo_r[23:0], !rtry[25]};
    tdiff = 17'(it_r.temp) - 17'(low_r);
  end

  assign we    = (st_r == S_CLR) || (st_r == S_SMTH);
  assign waddr = (st_r == S_CLR) ? clr_r[PixW-1:0] : it_r.pix;
  assign wdata = (st_r == S_CLR) ? 16'd0 : smooth_c;
  assign q_pop = (st_r == S_IDLE) && q_valid && !ov_r;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (clr_r == (PixW+1)'(SensorPixels - 1)) st_nxt = S_IDLE;
      S_IDLE: if (q_pop) st_nxt = S_RD;
      S_RD: begin
        if (it_r.op == OP_SAMPLE) st_nxt = S_SMTH;
        else if (it_r.temp <= low_r || it_r.temp >= high_r) st_nxt = S_COL;
        else st_nxt = S_DIV;
      end
      S_SMTH: st_nxt = it_r.last ? S_MUL : S_OUT;
      S_MUL:  st_nxt = S_LIM;
      S_LIM:  st_nxt = S_OUT;
      S_DIV:  if (dcnt_r == 5'd0) st_nxt = S_COL;
      S_COL:  st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
      low_r <= LOW_RST;
      high_r <= HIGH_RST;
      min_r <= MIN_RST;
      max_r <= MAX_RST;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (st_r == S_SMTH) begin
        min_r <= it_r.last ? MIN_RST : nmin;
        max_r <= it_r.last ? MAX_RST : nmax;
      end
      if (st_r == S_LIM) begin
        low_r  <= sat16(nl);
        high_r <= sat16(nh);
      end
      if (st_r == S_OUT) ov_r <= 1'b1;
    end
    if (q_pop) it_r <= q_item;
    if (st_r == S_SMTH) begin
      smooth_r <= smooth_c;
      fmin_r   <= nmin;
      fmax_r   <= nmax;
    end
    if (st_r == S_MUL) begin
      pl_r <= 34'(signed'({1'b0, kl})) * 34'(dl);
      ph_r <= 34'(signed'({1'b0, kh})) * 34'(dh);
    end
    if (st_r == S_RD) begin
      fmin_r <= min_r;
      fmax_r <= max_r;
      smooth_r <= '0;
      rem_r  <= '0;
      den_r  <= 17'(spread);
      quo_r  <= 25'({8'd0, tdiff[16:0]} * 25'd255);
      dcnt_r <= 5'd24;
      idx_r  <= (it_r.temp <= low_r) ? '0 : IdxW'(PaletteEntries - 1);
    end
    if (st_r == S_DIV) begin
      // shift-subtract restoring step
      if (!rtry[25]) rem_r <= rtry[24:0];
      else rem_r <= {rem_r[23:0], quo_r[24]};
      quo_r  <= {quo_r[23:0], !rtry[25]};
      dcnt_r <= dcnt_r - 1'b1;
    end
    // take the quotient including the bit of the final step
    if (st_r == S_DIV && dcnt_r == 5'd0) begin
      idx_r <= (qfin > 25'd255) ? 8'd255 : qfin[7:0];
    end
    if (st_r == S_OUT) begin
      res_r.smooth <= smooth_r;
      res_r.color  <= (it_r.op == OP_COLOR) ? palette(idx_r) : 16'd0;
      res_r.low    <= low_r;
      res_r.high   <= high_r;
      res_r.fmin   <= fmin_r;
      res_r.fmax   <= fmax_r;
    end
  end
endmodule

[rtl/core/thermal_autorange_false_color.sv]
// Top level of the thermal auto-range false-color block.
// Depends on tafc_pkg, tafc_front and tafc_back.
//
//  channel | ports                          | direction
//  input   | in_valid/in_stall, fields      | item in
//  result  | out_valid/out_stall, fields    | item out
//  config  | cfg_we, cfg_index, cfg_data    | register write
//
// A sample item passes the read, smoothing and output states (on a frame's
// last pixel also the limit multiply and update states); a color item in
// range passes the one-bit-per-cycle palette index divider. After reset the
// smoothing store is cleared before the first item is processed. A two-entry
// queue takes input while the back end is busy or the result is stalled.
`timescale 1ns / 1ps
module thermal_autorange_false_color (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [15:0] in_temperature,
  input  logic [5:0]         in_pixel_index,
  input  logic               in_frame_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_smoothed_value,
  output logic [15:0]        out_color,
  output logic signed [15:0] out_low_limit_out,
  output logic signed [15:0] out_high_limit_out,
  output logic signed [15:0] out_frame_min,
  output logic signed [15:0] out_frame_max,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tafc_pkg::*;
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;
  logic [15:0] fast_r, slow_r, thresh_r;

  assign in_item = '{op: in_opcode, temp: in_temperature,
                     pix: in_pixel_index[PixW-1:0], last: in_frame_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r   <= FAST_RST;
      slow_r   <= SLOW_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST:   fast_r   <= cfg_data;
        REG_SLOW:   slow_r   <= cfg_data;
        REG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tafc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  tafc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .fast_gain(fast_r), .slow_gain(slow_r), .spread_threshold(thresh_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_smoothed_value = res.smooth;
  assign out_color          = res.color;
  assign out_low_limit_out  = res.low;
  assign out_high_limit_out = res.high;
  assign out_frame_min      = res.fmin;
  assign out_frame_max      = res.fmax;
endmodule

[rtl/core/tafc_checker.sv]
// Port-level checker for the thermal false-color block, bound to the top level.
// Depends on thermal_autorange_false_color_macros.svh.
`timescale 1ns / 1ps
`include "thermal_autorange_false_color_macros.svh"
module tafc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_color,
  input logic [15:0] out_smoothed_value
);
  `TAFC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `TAFC_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_color))
  `TAFC_ASSERT_IMP(a_one_zero, out_valid, out_color == 16'd0 || out_smoothed_value == 16'd0)
endmodule

bind thermal_autorange_false_color tafc_checker u_tafc_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_color(out_color),
  .out_smoothed_value(out_smoothed_value)
);
